// ===== sv/ptt_pkg.sv =====
`default_nettype none

package ptt_pkg;

    localparam int MAX_SLOTS_DEF   = 16;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int MAX_RESULTS     = 16;
    localparam int PERIOD_W        = 32;
    localparam int KIND_W          = 2;
    localparam int SLOT_W          = 4;
    localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_FIRED      = 2'd0,
        KIND_REGISTERED = 2'd1,
        KIND_FULL       = 2'd2
    } kind_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic take;        // input beat accepted this cycle
        logic reg_commit;  // finish a register item
        logic scan_step;   // retire the slot under test
        logic flush;       // end of tick: bump counter, emit last firing
    } ctl_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_reg;       // action of the offered input beat
        logic table_empty;  // no filled slots
        logic scan_end;     // slot under test is the last filled one
        logic fire_report;  // slot under test fires and is reported
        logic pend_valid;   // a firing waits to be emitted
        logic out_free;     // output register can take a beat
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/ptt_ram.sv =====
`default_nettype none

module ptt_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/ptt_ctrl.sv =====
`default_nettype none

module ptt_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire ptt_pkg::dp_stat_t  stat,
    output ptt_pkg::ctl_cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_REG   = 4'b0010,
        S_SCAN  = 4'b0100,
        S_FLUSH = 4'b1000
    } ptt_state_t;

    ptt_state_t state_reg;
    ptt_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.take = 1'b1;
                    if (stat.is_reg)
                    begin
                        state_next = S_REG;
                    end
                    else if (stat.table_empty)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_REG:
            begin
                if (stat.out_free)
                begin
                    cmd.reg_commit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_SCAN:
            begin
                // hold while a pending firing has nowhere to go
                if (!(stat.fire_report && stat.pend_valid && !stat.out_free))
                begin
                    cmd.scan_step = 1'b1;
                    if (stat.scan_end)
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH:
            begin
                if (!stat.pend_valid || stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ptt_dp.sv =====
`default_nettype none

module ptt_dp #(
    parameter int MAX_SLOTS   = ptt_pkg::MAX_SLOTS_DEF,
    parameter int COUNT_WIDTH = ptt_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          action,
    input  wire logic [ptt_pkg::PERIOD_W-1:0]  period_ticks,
    input  wire logic                          result_stall,
    output logic                               result_valid,
    output logic      [ptt_pkg::KIND_W-1:0]    kind,
    output logic      [ptt_pkg::SLOT_W-1:0]    slot_index,
    output logic                               last,
    input  wire ptt_pkg::ctl_cmd_t             cmd,
    output ptt_pkg::dp_stat_t                  stat
);

    localparam int CW     = COUNT_WIDTH;
    localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int FILL_W = $clog2(MAX_SLOTS + 1);
    localparam int SW     = ptt_pkg::SLOT_W;
    localparam int RCW    = ptt_pkg::RES_CNT_W;

    logic [CW-1:0]                   count_reg;
    logic [CW-1:0]                   count_next;
    logic [FILL_W-1:0]               fill_reg;
    logic [FILL_W-1:0]               fill_next;
    logic [IDX_W-1:0]                idx_reg;
    logic [IDX_W-1:0]                idx_next;
    logic [RCW-1:0]                  res_cnt_reg;
    logic [RCW-1:0]                  res_cnt_next;
    logic                            pend_valid_reg;
    logic                            pend_valid_next;
    logic [SW-1:0]                   pend_slot_reg;
    logic [SW-1:0]                   pend_slot_next;
    logic [ptt_pkg::PERIOD_W-1:0]    period_reg;
    logic [ptt_pkg::PERIOD_W-1:0]    period_next;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    ptt_pkg::kind_t                  out_kind_reg;
    ptt_pkg::kind_t                  out_kind_next;
    logic [SW-1:0]                   out_slot_reg;
    logic [SW-1:0]                   out_slot_next;
    logic                            out_last_reg;
    logic                            out_last_next;

    logic                            full;
    logic                            out_free;
    logic                            scan_end;
    logic                            fire;
    logic                            fire_report;
    logic [CW-1:0]                   rd_due;
    logic [CW-1:0]                   rd_period;

    logic                            ram_we;
    logic [IDX_W-1:0]                ram_waddr;
    logic [2*CW-1:0]                 ram_wdata;
    logic                            ram_re;
    logic [IDX_W-1:0]                ram_raddr;
    logic [2*CW-1:0]                 ram_rdata;

    // one entry per slot: period in the upper half, due time in the lower
    ptt_ram #(
        .WIDTH  (2 * CW),
        .DEPTH  (MAX_SLOTS),
        .ADDR_W (IDX_W)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_due      = ram_rdata[CW-1:0];
    assign rd_period   = ram_rdata[2*CW-1:CW];
    assign full        = (fill_reg == FILL_W'(MAX_SLOTS));
    assign out_free    = !out_valid_reg || !result_stall;
    assign scan_end    = ((FILL_W'(idx_reg) + FILL_W'(1)) == fill_reg);
    assign fire        = (rd_due == count_reg);
    assign fire_report = fire && (res_cnt_reg < RCW'(ptt_pkg::MAX_RESULTS));

    assign stat.is_reg      = action;
    assign stat.table_empty = (fill_reg == '0);
    assign stat.scan_end    = scan_end;
    assign stat.fire_report = fire_report;
    assign stat.pend_valid  = pend_valid_reg;
    assign stat.out_free    = out_free;

    // read slot 0 at acceptance, then the next slot each step
    assign ram_re    = cmd.take || (cmd.scan_step && !scan_end);
    assign ram_raddr = cmd.take ? '0 : IDX_W'(idx_reg + IDX_W'(1));

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = {rd_period, CW'(rd_due + rd_period)};
        if (cmd.reg_commit)
        begin
            ram_we    = !full;
            ram_waddr = fill_reg[IDX_W-1:0];
            ram_wdata = {CW'(period_reg), count_reg};
        end
        else if (cmd.scan_step)
        begin
            ram_we = fire;
        end
    end

    always_comb
    begin
        count_next      = count_reg;
        fill_next       = fill_reg;
        idx_next        = idx_reg;
        res_cnt_next    = res_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        period_next     = period_reg;
        out_valid_next  = out_valid_reg && result_stall;
        out_kind_next   = out_kind_reg;
        out_slot_next   = out_slot_reg;
        out_last_next   = out_last_reg;

        if (cmd.take)
        begin
            idx_next        = '0;
            res_cnt_next    = '0;
            pend_valid_next = 1'b0;
            period_next     = period_ticks;
        end

        if (cmd.reg_commit)
        begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b1;
            if (full)
            begin
                out_kind_next = ptt_pkg::KIND_FULL;
                out_slot_next = '0;
            end
            else
            begin
                out_kind_next = ptt_pkg::KIND_REGISTERED;
                out_slot_next = SW'(fill_reg);
                fill_next     = fill_reg + FILL_W'(1);
            end
        end

        if (cmd.scan_step)
        begin
            idx_next = IDX_W'(idx_reg + IDX_W'(1));
            if (fire_report)
            begin
                res_cnt_next    = res_cnt_reg + RCW'(1);
                pend_valid_next = 1'b1;
                pend_slot_next  = SW'(idx_reg);
                // a later firing exists, so the pending one is not the last
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = ptt_pkg::KIND_FIRED;
                    out_slot_next  = pend_slot_reg;
                    out_last_next  = 1'b0;
                end
            end
        end

        if (cmd.flush)
        begin
            count_next      = CW'(count_reg + CW'(1));
            pend_valid_next = 1'b0;
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = ptt_pkg::KIND_FIRED;
                out_slot_next  = pend_slot_reg;
                out_last_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            fill_reg       <= '0;
            idx_reg        <= '0;
            res_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            fill_reg       <= fill_next;
            idx_reg        <= idx_next;
            res_cnt_reg    <= res_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_slot_reg <= pend_slot_next;
        period_reg    <= period_next;
        out_kind_reg  <= out_kind_next;
        out_slot_reg  <= out_slot_next;
        out_last_reg  <= out_last_next;
    end

    assign result_valid = out_valid_reg;
    assign kind         = out_kind_reg;
    assign slot_index   = out_slot_reg;
    assign last         = out_last_reg;

endmodule

`default_nettype wire

// ===== sv/periodic_task_table.sv =====
// Register item: after acceptance the controller waits in the register state until the
//   output register is free, then commits; no next item is taken until that commit.
// Tick item: one slot per cycle through the single read port of the slot RAM, then a flush;
//   the scan holds while a pending firing waits for the output register when it is stalled.
// Reset (rst_n, async, low) clears the tick counter, the fill count and the controller;
//   the slot RAM is not cleared, since only slots below the fill count are read.
`default_nettype none

module periodic_task_table #(
    parameter int MAX_SLOTS   = ptt_pkg::MAX_SLOTS_DEF,
    parameter int COUNT_WIDTH = ptt_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input channel
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire logic                          action,
    input  wire logic [ptt_pkg::PERIOD_W-1:0]  period_ticks,
    // result channel
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic      [ptt_pkg::KIND_W-1:0]    kind,
    output logic      [ptt_pkg::SLOT_W-1:0]    slot_index,
    output logic                               last
);

    ptt_pkg::ctl_cmd_t cmd;
    ptt_pkg::dp_stat_t stat;

    // Controller: idle -> register commit, or idle -> slot scan -> flush, or idle -> flush on an empty table.
    // It only sequences; all state of the table lives in the datapath.
    ptt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    // Datapath: tick counter, fill count, slot RAM, scan index and the
    // one-deep pending firing that lets the last firing of a tick carry
    // the last flag without looking ahead. The output register parts the
    // scan from a stalled consumer.
    ptt_dp #(
        .MAX_SLOTS   (MAX_SLOTS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .action       (action),
        .period_ticks (period_ticks),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .kind         (kind),
        .slot_index   (slot_index),
        .last         (last),
        .cmd          (cmd),
        .stat         (stat)
    );

    // at most one command per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.take, cmd.reg_commit, cmd.scan_step, cmd.flush}))
        else $error("controller issued more than one command");

    // an accepted beat is worked on alone: no second beat in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("input taken while an item is in progress");

    // a finished item returns the controller to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.flush || cmd.reg_commit) |=> !item_stall)
        else $error("controller did not return to idle");

    // a register commit always produces a result beat with last set
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.reg_commit |=> (result_valid && last))
        else $error("register item produced no final beat");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int SLOTS       = ptt_pkg::MAX_SLOTS_DEF;
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int TAIL_CYCLES = 60;    // a full tick scan plus margin
    localparam int DRAIN_BOUND = 20000;

    // one expected result beat
    typedef struct {
        ptt_pkg::kind_t             kind;
        logic [ptt_pkg::SLOT_W-1:0] slot;
        logic                       last;
    } result_beat_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         item_valid = 1'b0;
    logic                         item_stall;
    logic                         action = 1'b0;
    logic [ptt_pkg::PERIOD_W-1:0] period_ticks = '0;
    logic                         result_valid;
    logic                         result_stall = 1'b0;
    logic [ptt_pkg::KIND_W-1:0]   kind;
    logic [ptt_pkg::SLOT_W-1:0]   slot_index;
    logic                         last;

    // shadow copy of the task table
    logic [31:0]         tick_now;
    int                  slots_used;
    logic [31:0]         due_at [SLOTS];
    logic [31:0]         period_of [SLOTS];

    result_beat_t        pending_results [$];
    int                  mismatch_count = 0;

    // knobs shared between the test tasks and the result-side process
    bit                  idle_on = 1'b1;
    bit                  hold_request = 1'b0;
    int                  stall_run_left = 0;

    periodic_task_table DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .action       (action),
        .period_ticks (period_ticks),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .slot_index   (slot_index),
        .last         (last)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Safety net: end the run if the block hangs.
    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Gap length: mostly zero or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Period mix: mostly small so slots keep firing, some full-range values.
    function automatic logic [31:0] pick_period();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return $urandom_range(1, 12);
        else if (r < 7)
            return $urandom_range(0, 64);
        return $urandom();
    endfunction

    // Update the shadow table for one accepted beat and queue its results.
    task automatic predict_table_beat(input logic act, input logic [31:0] per);
        logic [31:0] old_count;
        int          hits [$];
        result_beat_t rb;
        if (act)
        begin
            if (slots_used < SLOTS)
            begin
                // new slot is due right now
                due_at[slots_used]    = tick_now;
                period_of[slots_used] = per;
                rb.kind = ptt_pkg::KIND_REGISTERED;
                rb.slot = slots_used[ptt_pkg::SLOT_W-1:0];
                slots_used++;
            end
            else
            begin
                // table full: no state change
                rb.kind = ptt_pkg::KIND_FULL;
                rb.slot = '0;
            end
            rb.last = 1'b1;
            pending_results.push_back(rb);
        end
        else
        begin
            old_count = tick_now;
            // scan filled slots in order; advance every due slot by its period
            for (int i = 0; i < slots_used; i++)
            begin
                if (due_at[i] == old_count)
                begin
                    if (hits.size() < ptt_pkg::MAX_RESULTS)
                        hits.push_back(i);
                    due_at[i] = old_count + period_of[i];
                end
            end
            tick_now = old_count + 32'd1;
            foreach (hits[k])
            begin
                rb.kind = ptt_pkg::KIND_FIRED;
                rb.slot = hits[k][ptt_pkg::SLOT_W-1:0];
                rb.last = (k == hits.size() - 1);
                pending_results.push_back(rb);
            end
        end
    endtask

    // Offer one beat, hold it until accepted, then predict it.
    // Valid stays high after acceptance so back-to-back beats need no toggle.
    task automatic send_beat(input logic act, input logic [31:0] per);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid   <= 1'b1;
        action       <= act;
        period_ticks <= per;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predict_table_beat(act, per);
    endtask

    // Drop valid and wait until every queued result has come back.
    task automatic pause_until_drained();
        int waited;
        waited = 0;
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 && waited < DRAIN_BOUND)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    task automatic flag_mismatch(input string what, input result_beat_t want);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch (%s) at %0t: expected kind=%0d slot=%0d last=%0d, %s%0d %s%0d %s%0d",
                     what, $realtime, want.kind, want.slot, want.last,
                     "got kind=", kind, "slot=", slot_index, "last=", last);
    endtask

    // Result checker: compare each accepted result beat with the oldest expectation.
    always @(posedge clk)
    begin
        result_beat_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                want.kind = ptt_pkg::KIND_FIRED;
                want.slot = '0;
                want.last = 1'b0;
                flag_mismatch("unexpected result", want);
            end
            else
            begin
                want = pending_results.pop_front();
                if (kind !== want.kind)
                    flag_mismatch("kind", want);
                else if (slot_index !== want.slot)
                    flag_mismatch("slot_index", want);
                else if (last !== want.last)
                    flag_mismatch("last", want);
            end
        end
    end

    // Receiver: random stall runs, or one long hold-off when a test asks for it.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_stall   <= 1'b0;
                stall_run_left = 0;
                hold_request   = 1'b0;
            end
            else if (!idle_on)
                result_stall <= 1'b0;
            else if (stall_run_left > 0)
                stall_run_left--;
            else if ($urandom_range(0, 3) == 0)
            begin
                result_stall   <= 1'b1;
                stall_run_left = pick_gap();
            end
            else
            begin
                result_stall   <= 1'b0;
                stall_run_left = $urandom_range(0, 8);
            end
        end
    end

    // Tick before any slot exists: nothing fires, the counter still advances.
    task automatic test_empty_tick();
        send_beat(1'b0, $urandom());
    endtask

    // Register slots with extreme periods, then tick: all fire together first,
    // the zero-period slot then holds its due time and goes quiet.
    task automatic test_register_extremes();
        send_beat(1'b1, 32'd1);
        send_beat(1'b1, 32'd0);
        send_beat(1'b1, 32'hFFFF_FFFF);
        send_beat(1'b1, 32'd2);
        send_beat(1'b1, 32'h8000_0000);
        repeat (4) send_beat(1'b0, $urandom());
    endtask

    // Fill the rest of the table, hit the full case, then fire the new batch.
    task automatic test_fill_table();
        while (slots_used < SLOTS)
            send_beat(1'b1, $urandom_range(1, 12));
        send_beat(1'b1, 32'd0);
        send_beat(1'b1, 32'hFFFF_FFFF);
        send_beat(1'b0, $urandom());
    endtask

    // Mostly ticks with firings, a few register beats against the full table.
    task automatic test_random_traffic(input int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 8)
                send_beat(1'b1, pick_period());
            else
                send_beat(1'b0, $urandom());
        end
    endtask

    // Hold the receiver off for a long stretch while ticks keep coming, so the
    // block backs up and stalls its input.
    task automatic test_output_holdoff();
        hold_request = 1'b1;
        test_random_traffic(30);
        while (hold_request)
            @(posedge clk);
    endtask

    // Let everything drain, then run a stretch with no idling on either side.
    task automatic test_drain_and_burst();
        pause_until_drained();
        idle_on = 1'b0;
        test_random_traffic(20);
        idle_on = 1'b1;
    endtask

    initial
    begin
        tick_now   = '0;
        slots_used = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_tick();
        test_register_extremes();
        test_fill_table();
        test_random_traffic(200);
        test_output_holdoff();
        test_drain_and_burst();

        // Drain, then watch a little longer for stray beats.
        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0d expected results never arrived", pending_results.size());
            mismatch_count += pending_results.size();
        end
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== periodic_task_table.f =====
sv/ptt_pkg.sv
sv/ptt_ram.sv
sv/ptt_ctrl.sv
sv/ptt_dp.sv
sv/periodic_task_table.sv
sim/testbench.sv
